// ===== design/jsd_pkg.sv =====
// shared types and constants for the jpeg scan destuffer
package jsd_pkg;

    localparam int ByteW  = 8;
    localparam int CountW = 9;
    localparam int RstW   = 3;

    localparam logic [ByteW-1:0] ByteFf    = 8'hFF;
    localparam logic [ByteW-1:0] ByteZero  = 8'h00;
    localparam logic [4:0]       RstPrefix = 5'b11010;   // upper bits of 0xD0..0xD7
    localparam logic [ByteW-1:0] SatMax    = 8'hFF;

    localparam logic KindData = 1'b0;
    localparam logic KindEnd  = 1'b1;

    localparam int InTdataW  = 8;
    localparam int OutTdataW = 24;

    typedef struct packed {
        logic             kind;
        logic [ByteW-1:0] out_byte;
        logic [ByteW-1:0] trailing_restarts;
        logic             count_overflow;
    } jsd_result_t;

endpackage

// ===== design/jsd_in_stage.sv =====
// input register stage: holds one accepted byte until the decoder takes it
module jsd_in_stage
    import jsd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [ByteW-1:0] s_byte,
    input  logic             take,
    output logic             byte_valid,
    output logic [ByteW-1:0] byte_data
);

    logic             valid_reg, valid_next;
    logic [ByteW-1:0] byte_reg;

    assign s_tready   = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            byte_reg <= s_byte;
        end
    end

endmodule

// ===== design/jsd_unstuff.sv =====
// scan state and unstuffing decision for one byte
module jsd_unstuff
    import jsd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic [ByteW-1:0] in_byte,
    output logic             has_result,
    output jsd_result_t      result
);

    logic              pending_reg, pending_next;
    logic [RstW-1:0]   expected_reg, expected_next;
    logic [CountW-1:0] count_reg, count_next;
    logic              is_rst;
    logic              ovf;

    assign is_rst = (in_byte == {RstPrefix, expected_reg});
    assign ovf    = count_reg[CountW-1];

    always_comb begin
        pending_next  = pending_reg;
        expected_next = expected_reg;
        count_next    = count_reg;
        has_result    = 1'b0;
        result.kind              = KindData;
        result.out_byte          = in_byte;
        result.trailing_restarts = ByteZero;
        result.count_overflow    = 1'b0;
        if (!pending_reg) begin
            if (in_byte == ByteFf) begin
                pending_next = 1'b1;
            end else begin
                count_next = '0;
                has_result = 1'b1;
            end
        end else begin
            pending_next = 1'b0;
            if (in_byte == ByteZero) begin
                count_next      = '0;
                has_result      = 1'b1;
                result.out_byte = ByteFf;
            end else if (is_rst) begin
                expected_next = expected_reg + 1'b1;
                // saturate at 256, meaning more than 255
                if (!ovf) begin
                    count_next = count_reg + 1'b1;
                end
            end else begin
                // any other marker ends the scan and clears all state
                has_result               = 1'b1;
                result.kind              = KindEnd;
                result.trailing_restarts = ovf ? SatMax : count_reg[ByteW-1:0];
                result.count_overflow    = ovf;
                expected_next            = '0;
                count_next               = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= 1'b0;
            expected_reg <= '0;
            count_reg    <= '0;
        end else if (advance) begin
            pending_reg  <= pending_next;
            expected_reg <= expected_next;
            count_reg    <= count_next;
        end
    end

endmodule

// ===== design/jpeg_scan_destuffer.sv =====
// Removes byte stuffing and restart markers from a jpeg scan byte stream.
// The slave channel (s_tvalid, s_tready, s_tdata) takes one raw scan byte per
// transaction. The master channel (m_tvalid, m_tready, m_tdata, m_tuser) gives
// a data byte (m_tuser 0) or an end-of-scan record (m_tuser 1) with the marker
// code, the restart markers seen since the last data byte and an overflow flag.
// A lone 0xFF and an expected restart marker give no transaction.
// An accepted byte passes through the input register and then the output
// register before its record is on m_tdata.
// Throughput: one byte per cycle while m_tready is high, set by the input
// register feeding the output register through a single level of decode logic.
// After an end-of-scan record the block is back in its reset state.
// When m_tready is low the output register holds its record, the input
// register still takes one more byte, and s_tready then drops until the
// output drains.
// Reset (aresetn low, synchronous) empties both registers and clears the
// held-0xFF flag, the restart index and the trailing restart count.
module jpeg_scan_destuffer
    import jsd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [InTdataW-1:0]  s_tdata,   // [7:0] data_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OutTdataW-1:0] m_tdata,   // [7:0] out_byte, [15:8] trailing_restarts,
                                            // [16] count_overflow, [23:17] zero
    output logic                 m_tuser    // [0] kind
);

    logic             byte_valid;
    logic [ByteW-1:0] byte_data;
    logic             advance;
    logic             has_result;
    jsd_result_t      result;

    logic             out_valid_reg, out_valid_next;
    jsd_result_t      out_reg;

    assign advance = byte_valid && (!out_valid_reg || m_tready);

    jsd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_byte     (s_tdata[ByteW-1:0]),
        .take       (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    jsd_unstuff u_unstuff (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .in_byte    (byte_data),
        .has_result (has_result),
        .result     (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = has_result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && has_result) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {7'b0, out_reg.count_overflow, out_reg.trailing_restarts,
                       out_reg.out_byte};

endmodule
